FILE: design/led_strip_pulse_encoder_assert.svh
// ----------------------------------------------------------------------------
// LED strip pulse encoder assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PULSE_ENCODER_ASSERT_SVH
`define LED_STRIP_PULSE_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clock, suspended while reset is high.
`define LSPE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lspe assertion failed");

// Checked on every rising edge of clock, reset included.
`define LSPE_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("lspe assertion failed");

`else

`define LSPE_ASSERT(label, prop)
`define LSPE_ASSERT_ALWAYS(label, prop)

`endif

`endif

FILE: design/lspe_pkg.sv
// ----------------------------------------------------------------------------
// LED strip pulse encoder package
// Shared constants, opcodes and transfer types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lspe_pkg;

   localparam int LED_COUNT   = 8;
   localparam int LED_W       = 3;
   localparam int COLOR_W     = 32;
   localparam int COLOR_IDX_W = $clog2(COLOR_W);
   localparam int TICK_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int COLOR_BITS_DEFAULT = 32;

   // Reset timing: nanosecond figures divided by a 5 ns tick.
   localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = TICK_W'(700 / 5);
   localparam logic [TICK_W-1:0] ONE_LOW_RESET   = TICK_W'(800 / 5);
   localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = TICK_W'(350 / 5);
   localparam logic [TICK_W-1:0] ZERO_LOW_RESET  = TICK_W'(600 / 5);
   localparam logic [TICK_W-1:0] GAP_RESET       = TICK_W'(60000 / 5);

   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP       = 3'd4;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_WRITE = 1'b1
   } lspe_op_type;

   typedef struct packed {
      logic [TICK_W-1:0] one_high_ticks;
      logic [TICK_W-1:0] one_low_ticks;
      logic [TICK_W-1:0] zero_high_ticks;
      logic [TICK_W-1:0] zero_low_ticks;
      logic [TICK_W-1:0] gap_ticks;
   } lspe_cfg_type;

   typedef struct packed {
      lspe_op_type        operation;
      logic [LED_W-1:0]   led_index;
      logic [COLOR_W-1:0] color_value;
      logic               right_button_raw;
      logic               down_button_raw;
   } lspe_item_type;

   typedef struct packed {
      logic line_level;
      logic right_pressed;
      logic down_pressed;
   } lspe_result_type;

endpackage

`default_nettype wire

FILE: design/lspe_csr.sv
// ----------------------------------------------------------------------------
// LED strip pulse encoder timing registers
// Holds the five pulse and gap lengths written through the register channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lspe_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   input  wire logic [lspe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lspe_pkg::TICK_W-1:0]    csr_data,
   output lspe_pkg::lspe_cfg_type              cfg
);
   import lspe_pkg::*;

   lspe_cfg_type cfg_ff;
   lspe_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ONE_HIGH:  cfg_in.one_high_ticks  = csr_data;
            CSR_ONE_LOW:   cfg_in.one_low_ticks   = csr_data;
            CSR_ZERO_HIGH: cfg_in.zero_high_ticks = csr_data;
            CSR_ZERO_LOW:  cfg_in.zero_low_ticks  = csr_data;
            CSR_GAP:       cfg_in.gap_ticks       = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high_ticks  <= ONE_HIGH_RESET;
         cfg_ff.one_low_ticks   <= ONE_LOW_RESET;
         cfg_ff.zero_high_ticks <= ZERO_HIGH_RESET;
         cfg_ff.zero_low_ticks  <= ZERO_LOW_RESET;
         cfg_ff.gap_ticks       <= GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/lspe_core.sv
// ----------------------------------------------------------------------------
// LED strip pulse encoder sequencer
// Color word store and the gap / high / low bit sequencer, one item per cycle while item_valid is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_strip_pulse_encoder_assert.svh"

module lspe_core #(
   parameter int COLOR_BITS = lspe_pkg::COLOR_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  lspe_pkg::lspe_item_type item,
   input  lspe_pkg::lspe_cfg_type  cfg,
   output lspe_pkg::lspe_result_type result
);
   import lspe_pkg::*;

   localparam int BIT_W = $clog2(COLOR_BITS);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_HIGH,
      PH_LOW,
      PH_TRAIL
   } phase_type;

   logic [COLOR_W-1:0] color_store_ff [LED_COUNT];
   phase_type          phase_ff, phase_in;
   logic [LED_W-1:0]   led_ff, led_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic               cur_bit_ff, cur_bit_in;
   logic               right_ff, right_in;
   logic               down_ff, down_in;

   logic [TICK_W-1:0]  tick_next;
   logic [TICK_W-1:0]  high_len;
   logic [TICK_W-1:0]  low_len;
   logic               store_bit;
   logic               high_bit;

   // The stored count never exceeds 65534, so the increment cannot wrap.
   assign tick_next = tick_ff + TICK_W'(1);
   assign store_bit = color_store_ff[led_ff][COLOR_IDX_W'(bit_ff)];
   // The color bit is sampled live on the first high tick of each bit.
   assign high_bit  = (tick_next == TICK_W'(1)) ? store_bit : cur_bit_ff;
   assign high_len  = high_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
   assign low_len   = cur_bit_ff ? cfg.one_low_ticks : cfg.zero_low_ticks;

   always_comb begin
      phase_in   = phase_ff;
      led_in     = led_ff;
      bit_in     = bit_ff;
      tick_in    = tick_ff;
      cur_bit_in = cur_bit_ff;
      right_in   = right_ff;
      down_in    = down_ff;
      if (item.operation == OP_TICK) begin
         tick_in = tick_next;
         unique case (phase_ff)
            PH_LEAD: begin
               if (tick_next >= cfg.gap_ticks) begin
                  tick_in  = '0;
                  phase_in = PH_HIGH;
               end
            end
            PH_HIGH: begin
               cur_bit_in = high_bit;
               if (tick_next >= high_len) begin
                  tick_in  = '0;
                  phase_in = PH_LOW;
               end
            end
            PH_LOW: begin
               if (tick_next >= low_len) begin
                  tick_in  = '0;
                  phase_in = PH_HIGH;
                  if (bit_ff != '0) begin
                     bit_in = bit_ff - BIT_W'(1);
                  end else begin
                     bit_in = BIT_W'(COLOR_BITS - 1);
                     if (led_ff == LED_W'(LED_COUNT - 1)) begin
                        led_in   = '0;
                        phase_in = PH_TRAIL;
                     end else begin
                        led_in = led_ff + LED_W'(1);
                     end
                  end
               end
            end
            PH_TRAIL: begin
               if (tick_next >= cfg.gap_ticks) begin
                  tick_in  = '0;
                  right_in = item.right_button_raw;
                  down_in  = item.down_button_raw;
                  phase_in = PH_LEAD;
               end
            end
            default: phase_in = PH_LEAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEAD;
         led_ff     <= '0;
         bit_ff     <= BIT_W'(COLOR_BITS - 1);
         tick_ff    <= '0;
         cur_bit_ff <= 1'b0;
         right_ff   <= 1'b0;
         down_ff    <= 1'b0;
         for (int i = 0; i < LED_COUNT; i++) begin
            color_store_ff[i] <= '0;
         end
      end else if (item_valid) begin
         phase_ff   <= phase_in;
         led_ff     <= led_in;
         bit_ff     <= bit_in;
         tick_ff    <= tick_in;
         cur_bit_ff <= cur_bit_in;
         right_ff   <= right_in;
         down_ff    <= down_in;
         // Every 3-bit index addresses an entry of the eight-word store.
         if (item.operation == OP_WRITE) begin
            color_store_ff[item.led_index] <= item.color_value;
         end
      end
   end

   // The pin shows the level held before the item moves the sequencer.
   assign result.line_level    = (phase_ff == PH_HIGH);
   assign result.right_pressed = right_in;
   assign result.down_pressed  = down_in;

   `LSPE_ASSERT(a_phase_change_clears_tick, !$stable(phase_ff) |-> tick_ff == '0)
   `LSPE_ASSERT(a_write_holds_sequencer,
      item_valid && item.operation == OP_WRITE |=> $stable(phase_ff) && $stable(tick_ff))
   `LSPE_ASSERT(a_flags_latch_after_trail,
      !$past(reset) && !$stable({right_ff, down_ff}) |-> $past(phase_ff) == PH_TRAIL)
   `LSPE_ASSERT_ALWAYS(a_reset_state,
      reset |=> phase_ff == PH_LEAD && tick_ff == '0 && led_ff == '0)

endmodule

`default_nettype wire

FILE: design/led_strip_pulse_encoder.sv
// Path: an item passes the input register, then the result register, before its
// result can transfer; a color write and a tick take the same path.
// Throughput: one item per cycle, sustained while the result side takes a transfer
// every cycle; the sequencer and store update in a single pass per item.
// Reset: synchronous, active high; the store, sequencer, flags and timing registers
// take their reset values together, with no clearing pass.
// ----------------------------------------------------------------------------
// LED strip pulse encoder
// One-wire LED strip pulse-width encoder with button status latching.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_strip_pulse_encoder #(
   parameter int COLOR_BITS = lspe_pkg::COLOR_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   // led_index[2:0], color_value[34:3], right_button_raw[35],
   // down_button_raw[36], zero fill[39:37]
   input  wire logic [39:0]                    req_tdata,
   // operation[0]
   input  wire logic                           req_tuser,
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // line_level[0], right_pressed[1], down_pressed[2], zero fill[7:3]
   output      logic [7:0]                     rsp_tdata,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [lspe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lspe_pkg::TICK_W-1:0]    csr_data
);
   import lspe_pkg::*;

   lspe_item_type   item_ff, item_in;
   logic            item_valid_ff;
   logic            rsp_valid_ff;
   lspe_result_type rsp_ff;
   lspe_result_type core_result;
   lspe_cfg_type    cfg;
   logic            fire;
   logic            req_fire;

   // The held item moves on when the result register is empty or drains now.
   assign fire       = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || fire;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      item_in.operation        = lspe_op_type'(req_tuser);
      item_in.led_index        = req_tdata[2:0];
      item_in.color_value      = req_tdata[34:3];
      item_in.right_button_raw = req_tdata[35];
      item_in.down_button_raw  = req_tdata[36];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            item_valid_ff <= 1'b1;
         end else if (fire) begin
            item_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (fire) begin
         rsp_ff <= core_result;
      end
   end

   lspe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lspe_core #(
      .COLOR_BITS (COLOR_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (fire),
      .item       (item_ff),
      .cfg        (cfg),
      .result     (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.down_pressed, rsp_ff.right_pressed, rsp_ff.line_level};

endmodule

`default_nettype wire

FILE: tb/lspe_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip encoder checker
// Watches the timing register port and both item streams. Every accepted
// item is run through a cycle-free model of the frame sequencer, and every
// accepted result is compared with the oldest predicted pin and status level.
// ----------------------------------------------------------------------------

module lspe_encoder_checker
   import lspe_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [39:0]          req_tdata,
   input  wire logic                 req_tuser,
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [7:0]           rsp_tdata,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]    csr_data,
   output int unsigned               fail_count = 0,
   output int unsigned               pending = 0
);

   typedef enum logic [1:0] {
      SEQ_LEAD,
      SEQ_HIGH,
      SEQ_LOW,
      SEQ_TRAIL
   } seq_phase_type;

   lspe_cfg_type           timing;
   logic [COLOR_W-1:0]     color_store [LED_COUNT];
   seq_phase_type          seq_phase;
   logic [LED_W-1:0]       led_pos;
   logic [COLOR_IDX_W-1:0] bit_pos;
   int unsigned            tick_count;
   logic                   sent_bit;
   logic                   right_flag;
   logic                   down_flag;
   lspe_result_type        strip_results [$];
   int unsigned            mismatches = 0;

   // Applies one item to the sequencer copy and returns the levels it shows.
   function automatic lspe_result_type advance_strip(input lspe_item_type item);
      lspe_result_type levels;
      int unsigned     span;
      // The pin reflects the phase before this item moves the sequencer.
      levels.line_level = (seq_phase == SEQ_HIGH);
      if (item.operation == OP_WRITE) begin
         color_store[item.led_index] = item.color_value;
      end else begin
         tick_count++;
         case (seq_phase)
            SEQ_LEAD: begin
               if (tick_count >= timing.gap_ticks) begin
                  tick_count = 0;
                  seq_phase  = SEQ_HIGH;
               end
            end
            SEQ_HIGH: begin
               // The color bit is fetched live on the first high tick.
               if (tick_count == 1) sent_bit = color_store[led_pos][bit_pos];
               span = sent_bit ? timing.one_high_ticks : timing.zero_high_ticks;
               if (tick_count >= span) begin
                  tick_count = 0;
                  seq_phase  = SEQ_LOW;
               end
            end
            SEQ_LOW: begin
               span = sent_bit ? timing.one_low_ticks : timing.zero_low_ticks;
               if (tick_count >= span) begin
                  tick_count = 0;
                  seq_phase  = SEQ_HIGH;
                  if (bit_pos != 0) begin
                     bit_pos--;
                  end else begin
                     bit_pos = COLOR_IDX_W'(COLOR_BITS_DEFAULT - 1);
                     if (led_pos == LED_W'(LED_COUNT - 1)) begin
                        led_pos   = '0;
                        seq_phase = SEQ_TRAIL;
                     end else begin
                        led_pos++;
                     end
                  end
               end
            end
            default: begin
               if (tick_count >= timing.gap_ticks) begin
                  tick_count = 0;
                  right_flag = item.right_button_raw;
                  down_flag  = item.down_button_raw;
                  seq_phase  = SEQ_LEAD;
               end
            end
         endcase
      end
      levels.right_pressed = right_flag;
      levels.down_pressed  = down_flag;
      return levels;
   endfunction

   always @(posedge clock) begin
      lspe_item_type   item;
      lspe_result_type seen;
      lspe_result_type want;
      if (reset) begin
         timing = '{ONE_HIGH_RESET, ONE_LOW_RESET, ZERO_HIGH_RESET, ZERO_LOW_RESET,
                    GAP_RESET};
         color_store = '{default: '0};
         seq_phase   = SEQ_LEAD;
         led_pos     = '0;
         bit_pos     = COLOR_IDX_W'(COLOR_BITS_DEFAULT - 1);
         tick_count  = 0;
         sent_bit    = 1'b0;
         right_flag  = 1'b0;
         down_flag   = 1'b0;
         strip_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ONE_HIGH:  timing.one_high_ticks  = csr_data;
               CSR_ONE_LOW:   timing.one_low_ticks   = csr_data;
               CSR_ZERO_HIGH: timing.zero_high_ticks = csr_data;
               CSR_ZERO_LOW:  timing.zero_low_ticks  = csr_data;
               CSR_GAP:       timing.gap_ticks       = csr_data;
               default: ;
            endcase
         end
         // Results are taken before new items, since a result always
         // belongs to an item accepted at an earlier edge.
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tdata[0], rsp_tdata[1], rsp_tdata[2]};
            if (strip_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t checker: unexpected result: pin %0b right %0b down %0b",
                           $realtime, seen.line_level, seen.right_pressed,
                           seen.down_pressed);
            end else begin
               want = strip_results.pop_front();
               if (want != seen) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%t checker: pin %0b/%0b right %0b/%0b down %0b/%0b (exp/got)",
                              $realtime, want.line_level, seen.line_level,
                              want.right_pressed, seen.right_pressed,
                              want.down_pressed, seen.down_pressed);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            item.operation        = lspe_op_type'(req_tuser);
            item.led_index        = req_tdata[2:0];
            item.color_value      = req_tdata[34:3];
            item.right_button_raw = req_tdata[35];
            item.down_button_raw  = req_tdata[36];
            strip_results.push_back(advance_strip(item));
         end
      end
      pending    <= strip_results.size();
      fail_count <= mismatches;
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip encoder testbench
// Drives host writes and tick items through the encoder under several timing
// settings and idle patterns, including a long result-side hold-off and a full
// drain, while a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb;
   import lspe_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 150;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TICK_W-1:0]    csr_data = '0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   logic        hold_trigger = 1'b0;
   logic        hold_seen = 1'b0;

   always #5 clock = ~clock;

   led_strip_pulse_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lspe_encoder_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Result side: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_trigger != hold_seen) begin
         hold_seen  <= hold_trigger;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic lspe_item_type strip_item(input lspe_op_type op,
                                                input logic [LED_W-1:0] led,
                                                input logic [COLOR_W-1:0] color,
                                                input logic right, input logic down);
      lspe_item_type item;
      item.operation        = op;
      item.led_index        = led;
      item.color_value      = color;
      item.right_button_raw = right;
      item.down_button_raw  = down;
      return item;
   endfunction

   function automatic lspe_item_type random_item();
      lspe_item_type item;
      item.operation        = ($urandom_range(99) < 12) ? OP_WRITE : OP_TICK;
      item.led_index        = LED_W'($urandom_range(LED_COUNT - 1));
      case ($urandom_range(3))
         0:       item.color_value = '0;
         1:       item.color_value = '1;
         default: item.color_value = $urandom;
      endcase
      item.right_button_raw = $urandom_range(1);
      item.down_button_raw  = $urandom_range(1);
      return item;
   endfunction

   // Short bit times keep whole frames, and so the button latching, in reach.
   function automatic lspe_cfg_type random_timing();
      lspe_cfg_type cfg;
      cfg.one_high_ticks  = TICK_W'($urandom_range(3));
      cfg.one_low_ticks   = TICK_W'($urandom_range(3));
      cfg.zero_high_ticks = TICK_W'($urandom_range(3));
      cfg.zero_low_ticks  = TICK_W'($urandom_range(3));
      cfg.gap_ticks       = TICK_W'($urandom_range(6));
      return cfg;
   endfunction

   // The valid stays high across back-to-back transfers; it is only
   // lowered for an idle cycle or a drain.
   task automatic send_item(input lspe_item_type item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.operation;
      req_tdata  <= {3'b000, item.down_button_raw, item.right_button_raw,
                     item.color_value, item.led_index};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_timing(input lspe_cfg_type cfg, input bit with_unused);
      logic [TICK_W-1:0] reg_value [5];
      int                last;
      reg_value = '{cfg.one_high_ticks, cfg.one_low_ticks, cfg.zero_high_ticks,
                    cfg.zero_low_ticks, cfg.gap_ticks};
      last = with_unused ? (1 << CSR_IDX_W) - 1 : CSR_GAP;
      for (int k = CSR_ONE_HIGH; k <= last; k++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_data  <= (k <= CSR_GAP) ? reg_value[k] : TICK_W'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input lspe_cfg_type cfg, input int unsigned tx_pct,
                             input int unsigned rx_pct, input int unsigned count);
      wait_drained();
      write_timing(cfg, 1'b0);
      tx_idle_pct = tx_pct;
      rx_stall_pct <= rx_pct;
      repeat (count) send_item(random_item());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset timing: the long leading gap holds the pin low throughout.
      send_item(strip_item(OP_WRITE, 3'd0, '1, 1'b1, 1'b1));
      send_item(strip_item(OP_WRITE, 3'd7, '0, 1'b0, 1'b0));
      send_item(strip_item(OP_WRITE, 3'd3, 32'h8000_0001, 1'b1, 1'b0));
      send_item(strip_item(OP_WRITE, 3'd5, 32'hA5A5_5A5A, 1'b0, 1'b1));
      send_item(strip_item(OP_TICK, 3'd7, '1, 1'b1, 1'b1));
      send_item(strip_item(OP_TICK, 3'd0, '0, 1'b0, 1'b0));
      send_item(strip_item(OP_TICK, 3'd0, '0, 1'b1, 1'b0));
      send_item(strip_item(OP_TICK, 3'd0, '0, 1'b0, 1'b1));

      // Zero-length phases, and writes to indexes past the register list.
      wait_drained();
      write_timing('{16'd0, 16'd1, 16'd1, 16'd0, 16'd0}, 1'b1);
      repeat (6) send_item(strip_item(OP_TICK, 3'd0, '0, 1'b1, 1'b1));
      // Rewrite the word that is currently going out.
      send_item(strip_item(OP_WRITE, 3'd0, '0, 1'b0, 1'b0));
      repeat (5) send_item(strip_item(OP_TICK, 3'd0, '1, 1'b0, 1'b1));
      send_item(strip_item(OP_WRITE, 3'd1, 32'hFFFF_0000, 1'b1, 1'b1));
      repeat (4) send_item(strip_item(OP_TICK, 3'd0, '0, 1'b1, 1'b0));

      // Longest lengths; the next setting then cuts the phase short.
      wait_drained();
      write_timing('{default: '1}, 1'b0);
      repeat (40) send_item(strip_item(OP_TICK, 3'd0, '0, $urandom_range(1),
                                       $urandom_range(1)));

      run_random('{default: '0}, 0, 0, 350);
      run_random('{16'd1, 16'd2, 16'd0, 16'd1, 16'd3}, 84, 0, 300);
      run_random(random_timing(), 0, 84, 300);
      run_random(random_timing(), 28, 28, 300);

      // Back-pressure: the result side holds off while items keep coming,
      // then the sender waits for a full drain before going on.
      run_random('{16'd2, 16'd1, 16'd1, 16'd2, 16'd1}, 0, 0, 60);
      hold_trigger <= ~hold_trigger;
      repeat (150) send_item(random_item());
      wait_drained();
      repeat (100) send_item(random_item());

      wait_drained();
      repeat (6) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/lspe_pkg.sv
design/lspe_csr.sv
design/lspe_core.sv
design/led_strip_pulse_encoder.sv
tb/lspe_encoder_checker.sv
tb/tb.sv
